>>> rtl/ffha_pkg.sv
package ffha_pkg;

   // default sizing of the block table and the block header
   localparam int DEF_MAX_BLOCKS   = 64;
   localparam int DEF_HEADER_BYTES = 5;

   // register file
   localparam int          CSR_IDX_W      = 1;
   localparam int          CSR_DATA_W     = 32;
   localparam logic [CSR_IDX_W-1:0] REG_HEAP_BASE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEAP_SIZE = 1'd1;
   localparam logic [31:0] HEAP_BASE_RESET = 32'h0000_1000;
   localparam logic [31:0] HEAP_SIZE_RESET = 32'h0100_0000;

   // request operations
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // response status codes
   localparam int STATUS_W = 3;
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_MEMORY  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN    = 3'd4;

endpackage

>>> rtl/ffha_ram.sv
module ffha_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/ffha_ctrl.sv
module ffha_ctrl #(
   parameter int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS,
   parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_operation,
   input  logic [31:0]                      req_request_size,
   input  logic [31:0]                      req_block_address,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [31:0]                      rsp_granted_address,
   output logic [ffha_pkg::STATUS_W-1:0]    rsp_status,
   output logic [31:0]                      rsp_bytes_in_use,
   // heap window
   input  logic [31:0]                      heap_base,
   input  logic [31:0]                      heap_size,
   // block table memory
   output logic                             ram_wr_en,
   output logic [$clog2(MAX_BLOCKS)-1:0]    ram_wr_addr,
   output logic [32:0]                      ram_wr_data,
   output logic [$clog2(MAX_BLOCKS)-1:0]    ram_rd_addr,
   input  logic [32:0]                      ram_rd_data
);

   import ffha_pkg::*;

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [31:0]      HDR      = 32'(HEADER_BYTES);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BLOCKS);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_WALK = 4'b0010,
      S_BUMP = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic                    op_ff, op_in;
   logic [31:0]             size_ff, size_in;
   logic [31:0]             addr_ff, addr_in;
   logic [IDX_W-1:0]        chk_ff, chk_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [31:0]             bump_ff, bump_in;
   logic [31:0]             used_ff, used_in;
   logic [31:0]             pay_ff, pay_in;
   logic [31:0]             granted_ff, granted_in;
   logic [STATUS_W-1:0]     status_ff, status_in;

   logic                    entry_in_use;
   logic [31:0]             entry_size;
   logic [31:0]             entry_span;
   logic [CNT_W-1:0]        chk_plus;
   logic                    last_entry;
   logic                    req_ignored;
   logic [33:0]             bump_end;

   assign entry_in_use = ram_rd_data[32];
   assign entry_size   = ram_rd_data[31:0];
   assign entry_span   = entry_size + HDR;
   assign chk_plus     = CNT_W'(chk_ff) + CNT_W'(1);
   assign last_entry   = (chk_plus == count_ff);
   assign bump_end     = {2'b00, bump_ff} + {2'b00, size_ff} + {2'b00, HDR};

   assign req_ignored = ((req_operation == OP_ALLOC) && (req_request_size == 32'd0)) ||
                        ((req_operation == OP_FREE) && (req_block_address == 32'd0));

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = (state_ff == S_DONE);
   assign rsp_granted_address = granted_ff;
   assign rsp_status          = status_ff;
   assign rsp_bytes_in_use    = used_ff;

   // table read runs one entry ahead of the compare
   assign ram_rd_addr = (state_ff == S_WALK) ? IDX_W'(chk_plus) : '0;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      size_in     = size_ff;
      addr_in     = addr_ff;
      chk_in      = chk_ff;
      count_in    = count_ff;
      bump_in     = bump_ff;
      used_in     = used_ff;
      pay_in      = pay_ff;
      granted_in  = granted_ff;
      status_in   = status_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = chk_ff;
      ram_wr_data = {1'b0, entry_size};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_operation;
               size_in    = req_request_size;
               addr_in    = req_block_address;
               chk_in     = '0;
               pay_in     = heap_base + HDR;
               granted_in = '0;
               if (req_ignored) begin
                  status_in = ST_IGNORED;
                  state_in  = S_DONE;
               end else if (count_ff != '0) begin
                  state_in = S_WALK;
               end else if (req_operation == OP_ALLOC) begin
                  state_in = S_BUMP;
               end else begin
                  status_in = ST_UNKNOWN;
                  state_in  = S_DONE;
               end
            end
         end

         S_WALK: begin
            if (op_ff == OP_ALLOC) begin
               // first free entry that is large enough
               if (!entry_in_use && (entry_size >= size_ff)) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = {1'b1, entry_size};
                  used_in     = used_ff + entry_span;
                  granted_in  = pay_ff;
                  status_in   = ST_OK;
                  state_in    = S_DONE;
               end else if (last_entry) begin
                  state_in = S_BUMP;
               end
            end else begin
               // entry whose payload address matches
               if (pay_ff == addr_ff) begin
                  if (entry_in_use) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_data = {1'b0, entry_size};
                     used_in     = used_ff - entry_span;
                     status_in   = ST_OK;
                  end else begin
                     status_in = ST_UNKNOWN;
                  end
                  state_in = S_DONE;
               end else if (last_entry) begin
                  status_in = ST_UNKNOWN;
                  state_in  = S_DONE;
               end
            end
            chk_in = IDX_W'(chk_plus);
            pay_in = pay_ff + entry_span;
         end

         S_BUMP: begin
            // append a new block at the end of the heap if it ends below heap_size and the table has room
            if (bump_end >= {2'b00, heap_size}) begin
               status_in = ST_NO_MEMORY;
            end else if (count_ff == CNT_FULL) begin
               status_in = ST_TABLE_FULL;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = count_ff[IDX_W-1:0];
               ram_wr_data = {1'b1, size_ff};
               count_in    = count_ff + CNT_W'(1);
               granted_in  = heap_base + bump_ff + HDR;
               bump_in     = bump_end[31:0];
               used_in     = used_ff + size_ff + HDR;
               status_in   = ST_OK;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         bump_ff  <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         bump_ff  <= bump_in;
         used_ff  <= used_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      size_ff    <= size_in;
      addr_ff    <= addr_in;
      chk_ff     <= chk_in;
      pay_ff     <= pay_in;
      granted_ff <= granted_in;
      status_ff  <= status_in;
   end

endmodule

>>> rtl/first_fit_heap_allocator.sv
// First-fit heap allocator. Each request (allocate or free) returns one response
// with the granted payload address, a status code and the bytes in use. Blocks
// live in a table memory of MAX_BLOCKS entries, each an in-use flag and a payload
// size, in address order. A request walks that table one entry per clock; an
// allocate with no fitting free entry tries to append a block at the end of the heap.
// Zero-size allocates and frees of address zero skip the walk and are ignored.
// The block accepts no new request until the response is taken.
// heap_base and heap_size should be written only while no request is in flight.
module first_fit_heap_allocator #(
   parameter int MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS,
   parameter int HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration writes
   input  logic                             csr_wr_en,
   input  logic [ffha_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ffha_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_operation,
   input  logic [31:0]                      req_request_size,
   input  logic [31:0]                      req_block_address,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [31:0]                      rsp_granted_address,
   output logic [ffha_pkg::STATUS_W-1:0]    rsp_status,
   output logic [31:0]                      rsp_bytes_in_use
);

   import ffha_pkg::*;

   localparam int IDX_W = $clog2(MAX_BLOCKS);

   logic [31:0]       heap_base_ff, heap_base_in;
   logic [31:0]       heap_size_ff, heap_size_in;
   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [32:0]       ram_wr_data;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [32:0]       ram_rd_data;

   // register writes
   always_comb begin
      heap_base_in = heap_base_ff;
      heap_size_in = heap_size_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_HEAP_BASE: heap_base_in = csr_wdata;
            REG_HEAP_SIZE: heap_size_in = csr_wdata;
            default: begin
               heap_base_in = heap_base_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= HEAP_BASE_RESET;
         heap_size_ff <= HEAP_SIZE_RESET;
      end else begin
         heap_base_ff <= heap_base_in;
         heap_size_ff <= heap_size_in;
      end
   end

   // block table: {in_use, size}
   ffha_ram #(
      .WIDTH (33),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // request sequencer and table walk
   ffha_ctrl #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_request_size    (req_request_size),
      .req_block_address   (req_block_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status),
      .rsp_bytes_in_use    (rsp_bytes_in_use),
      .heap_base           (heap_base_ff),
      .heap_size           (heap_size_ff),
      .ram_wr_en           (ram_wr_en),
      .ram_wr_addr         (ram_wr_addr),
      .ram_wr_data         (ram_wr_data),
      .ram_rd_addr         (ram_rd_addr),
      .ram_rd_data         (ram_rd_data)
   );

endmodule

>>> bench/first_fit_heap_allocator_test.sv
`timescale 1ns / 1ps

module first_fit_heap_allocator_test;
   import ffha_pkg::*;

   localparam int TABLE_DEPTH      = DEF_MAX_BLOCKS;
   localparam int HDR_BYTES        = DEF_HEADER_BYTES;
   localparam int DRAIN_CYCLES     = DEF_MAX_BLOCKS + 16;
   localparam int RANDOM_PER_PHASE = 185;
   localparam int PHASE_COUNT      = 4;
   localparam int HOLD_CYCLES      = 400;
   localparam int DIRECTED_ROWS    = 20;

   typedef struct packed {
      logic [31:0]         granted;
      logic [STATUS_W-1:0] status;
      logic [31:0]         in_use;
   } heap_reply_type;

   typedef struct packed {
      logic           op;
      logic [31:0]    size;
      logic [31:0]    addr;
      logic           fixed_reply;
      heap_reply_type reply;
   } directed_row_type;

   localparam heap_reply_type NO_REPLY = '0;

   // directed requests, replies typed in only where obvious from reset state
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{OP_ALLOC, 32'd0,         32'hFFFF_FFFF, 1'b1, '{32'd0, ST_IGNORED, 32'd0}},
      '{OP_FREE,  32'hFFFF_FFFF, 32'd0,         1'b1, '{32'd0, ST_IGNORED, 32'd0}},
      '{OP_FREE,  32'd0,         32'h0000_1005, 1'b1, '{32'd0, ST_UNKNOWN, 32'd0}},
      '{OP_ALLOC, 32'd10,        32'd0,         1'b1, '{32'h0000_1005, ST_OK, 32'd15}},
      '{OP_ALLOC, 32'hFFFF_FFFF, 32'd0,         1'b1, '{32'd0, ST_NO_MEMORY, 32'd15}},
      '{OP_ALLOC, 32'd20,        32'd0,         1'b0, NO_REPLY},
      '{OP_FREE,  32'd0,         32'h0000_1005, 1'b0, NO_REPLY},
      '{OP_FREE,  32'd0,         32'h0000_1005, 1'b0, NO_REPLY},
      '{OP_ALLOC, 32'd4,         32'd0,         1'b0, NO_REPLY},
      '{OP_FREE,  32'd0,         32'h0000_1006, 1'b0, NO_REPLY},
      '{OP_FREE,  32'd0,         32'hFFFF_FFFF, 1'b0, NO_REPLY},
      '{OP_ALLOC, 32'd1,         32'd0,         1'b0, NO_REPLY},
      '{OP_ALLOC, 32'd16777165,  32'd0,         1'b0, NO_REPLY},
      '{OP_ALLOC, 32'd16777164,  32'd0,         1'b0, NO_REPLY},
      '{OP_ALLOC, 32'd2,         32'd0,         1'b0, NO_REPLY},
      '{OP_FREE,  32'd0,         32'h0000_1033, 1'b0, NO_REPLY},
      '{OP_ALLOC, 32'h00FF_FFFF, 32'd0,         1'b0, NO_REPLY},
      '{OP_ALLOC, 32'd100,       32'd0,         1'b0, NO_REPLY},
      '{OP_FREE,  32'd0,         32'h0000_1014, 1'b0, NO_REPLY},
      '{OP_ALLOC, 32'h8000_0000, 32'h5555_5555, 1'b0, NO_REPLY}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_HEAP_BASE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_operation = OP_ALLOC;
   logic [31:0]           req_request_size = '0;
   logic [31:0]           req_block_address = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [31:0]           rsp_granted_address;
   logic [STATUS_W-1:0]   rsp_status;
   logic [31:0]           rsp_bytes_in_use;

   // shadow of the block table, registers and usage counters
   logic        blk_live  [TABLE_DEPTH];
   logic [31:0] blk_bytes [TABLE_DEPTH];
   int          blk_count = 0;
   logic [31:0] bump_end = '0;
   logic [31:0] charged_bytes = '0;
   logic [31:0] cfg_base = HEAP_BASE_RESET;
   logic [31:0] cfg_limit = HEAP_SIZE_RESET;

   heap_reply_type pending_replies [$];

   int fail_count = 0;
   int sent_count = 0;
   int reuse_count = 0;
   int status_tally [5] = '{0, 0, 0, 0, 0};
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int hold_asked = 0;
   int hold_taken = 0;
   int hold_left = 0;

   first_fit_heap_allocator DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_request_size    (req_request_size),
      .req_block_address   (req_block_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status),
      .rsp_bytes_in_use    (rsp_bytes_in_use)
   );

   always #4 clock = ~clock;

   // payload address of table entry k under the current heap base
   function automatic logic [31:0] payload_addr(int k);
      logic [63:0] off;
      off = '0;
      for (int j = 0; j < k; j++)
         off += 64'(blk_bytes[j]) + 64'(HDR_BYTES);
      return cfg_base + off[31:0] + 32'(HDR_BYTES);
   endfunction

   // first-fit allocate or free against the shadow table
   function automatic heap_reply_type heap_outcome(logic op, logic [31:0] size,
                                                   logic [31:0] addr);
      heap_reply_type r;
      int hit;
      r.granted = '0;
      r.status = ST_OK;
      hit = -1;
      if (op == OP_ALLOC) begin
         if (size == 0) begin
            r.status = ST_IGNORED;
         end else begin
            for (int k = 0; k < blk_count && hit < 0; k++)
               if (!blk_live[k] && blk_bytes[k] >= size) hit = k;
            if (hit >= 0) begin
               // reuse charges the stored size, never split
               blk_live[hit] = 1'b1;
               charged_bytes += blk_bytes[hit] + 32'(HDR_BYTES);
               r.granted = payload_addr(hit);
               reuse_count++;
            end else if (64'(bump_end) + 64'(size) + 64'(HDR_BYTES) >= 64'(cfg_limit)) begin
               r.status = ST_NO_MEMORY;
            end else if (blk_count >= TABLE_DEPTH) begin
               r.status = ST_TABLE_FULL;
            end else begin
               blk_live[blk_count] = 1'b1;
               blk_bytes[blk_count] = size;
               blk_count++;
               r.granted = cfg_base + bump_end + 32'(HDR_BYTES);
               bump_end += size + 32'(HDR_BYTES);
               charged_bytes += size + 32'(HDR_BYTES);
            end
         end
      end else if (addr == 0) begin
         r.status = ST_IGNORED;
      end else begin
         r.status = ST_UNKNOWN;
         for (int k = 0; k < blk_count && hit < 0; k++)
            if (payload_addr(k) == addr) hit = k;
         if (hit >= 0 && blk_live[hit]) begin
            blk_live[hit] = 1'b0;
            charged_bytes -= blk_bytes[hit] + 32'(HDR_BYTES);
            r.status = ST_OK;
         end
      end
      r.in_use = charged_bytes;
      return r;
   endfunction

   // present one request and record its reply once accepted
   task automatic offer(input logic op, input logic [31:0] size, input logic [31:0] addr,
                        input logic fixed_reply, input heap_reply_type reply);
      heap_reply_type predicted;
      @(negedge clock);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_request_size <= size;
      req_block_address <= addr;
      do @(posedge clock); while (!req_ready);
      predicted = heap_outcome(op, size, addr);
      status_tally[predicted.status]++;
      pending_replies.push_back(fixed_reply ? reply : predicted);
      sent_count++;
   endtask

   // drop valid and wait for every outstanding reply
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_HEAP_BASE) cfg_base = value;
      else cfg_limit = value;
   endtask

   // mostly well-formed traffic: frees of live blocks, sizes that fit free blocks
   task automatic pick_request(output logic op, output logic [31:0] size,
                               output logic [31:0] addr);
      int live_idx [$];
      int idle_idx [$];
      int r;
      int j;
      for (int k = 0; k < blk_count; k++)
         if (blk_live[k]) live_idx.push_back(k);
         else idle_idx.push_back(k);
      op = ($urandom_range(99) < 55) ? OP_ALLOC : OP_FREE;
      size = $urandom;
      addr = $urandom;
      r = $urandom_range(99);
      if (op == OP_ALLOC) begin
         if (r < 5) begin
            size = '0;
         end else if (r < 45 && idle_idx.size() > 0) begin
            j = idle_idx[$urandom_range(idle_idx.size() - 1)];
            size = $urandom_range(blk_bytes[j], 1);
         end else if (r < 90) begin
            size = $urandom_range(64, 1);
         end
      end else begin
         if (r < 70 && live_idx.size() > 0) begin
            addr = payload_addr(live_idx[$urandom_range(live_idx.size() - 1)]);
         end else if (r < 80 && idle_idx.size() > 0) begin
            addr = payload_addr(idle_idx[$urandom_range(idle_idx.size() - 1)]);
         end else if (r < 88 && blk_count > 0) begin
            addr = payload_addr($urandom_range(blk_count - 1)) + 32'd1;
         end else if (r < 93) begin
            addr = '0;
         end
      end
   endtask

   // receiver: random back-pressure plus one long hold-off
   always @(negedge clock) begin
      if (hold_taken != hold_asked) begin
         hold_taken = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // compare each reply against the oldest outstanding one
   always @(posedge clock) begin
      heap_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            $error("reply with no request outstanding: addr %h status %0d bytes %0d",
                   rsp_granted_address, rsp_status, rsp_bytes_in_use);
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_granted_address !== want.granted) begin
               $error("granted_address expected %h actual %h", want.granted,
                      rsp_granted_address);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_bytes_in_use !== want.in_use) begin
               $error("bytes_in_use expected %0d actual %0d", want.in_use,
                      rsp_bytes_in_use);
               fail_count++;
            end
         end
      end
   end

   initial begin
      logic        op;
      logic [31:0] size;
      logic [31:0] addr;
      logic [31:0] base;
      logic [31:0] limit;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed part under reset register values
      sender_idle_pct = 36;
      receiver_idle_pct = 83;
      for (int i = 0; i < DIRECTED_ROWS; i++)
         offer(directed_rows[i].op, directed_rows[i].size, directed_rows[i].addr,
               directed_rows[i].fixed_reply, directed_rows[i].reply);

      // random phases, each under its own heap base and size
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin
               base = '0;
               limit = '1;
            end
            1: begin
               base = 32'hFFFF_FFFB;
               limit = $urandom_range(32'h0400_0000, 32'h0000_1000);
               sender_idle_pct = 83;
               receiver_idle_pct = 36;
            end
            2: begin
               base = '1;
               limit = '0;
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
            end
            default: begin
               base = $urandom;
               limit = HEAP_SIZE_RESET;
            end
         endcase
         settle();
         write_reg(REG_HEAP_BASE, base);
         write_reg(REG_HEAP_SIZE, limit);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (p == 0 && n == 60) hold_asked++;
            pick_request(op, size, addr);
            offer(op, size, addr, 1'b0, NO_REPLY);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests over %0d heap settings, table reached %0d entries",
               sent_count, PHASE_COUNT + 1, blk_count);
      $display("ok %0d (reused %0d), ignored %0d, no memory %0d, table full %0d, unknown %0d",
               status_tally[ST_OK], reuse_count, status_tally[ST_IGNORED],
               status_tally[ST_NO_MEMORY], status_tally[ST_TABLE_FULL],
               status_tally[ST_UNKNOWN]);
      if (fail_count == 0)
         $display("first_fit_heap_allocator verification clean");
      else
         $display("first_fit_heap_allocator verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("timeout with %0d replies outstanding", pending_replies.size());
      $display("first_fit_heap_allocator verification failed");
      $finish;
   end

endmodule
